>>> hw/rtl/fresnel_reflectance_unpolarized_top_defines.svh
// ----------------------------------------------------------------------------
// Fresnel reflectance assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_REFLECTANCE_UNPOLARIZED_TOP_DEFINES_SVH
`define FRESNEL_REFLECTANCE_UNPOLARIZED_TOP_DEFINES_SVH

// check an implication sampled at every rising clock edge
`define FRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition leads to another in the next cycle
`define FRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared types, widths and constants of the reflectance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package frp_pkg;

    localparam int DIV_STEPS  = 29;
    localparam int SQRT_STEPS = 29;
    localparam int RAT_STEPS  = 19;
    localparam int RAT_LAT    = RAT_STEPS + 3;
    localparam int TAIL_LAT   = RAT_LAT + 2;

    localparam logic [15:0]        FULL_Q15 = 16'd32768;
    localparam logic signed [33:0] ONE_Q28  = 34'sd268435456;

    typedef logic signed [15:0] vec_t;
    typedef logic [15:0]        idx_t;
    typedef logic signed [29:0] cos_t;

    typedef struct packed {
        logic tir;
        logic nz;
        idx_t n1;
        idx_t n2;
        cos_t c;
    } side_t;

endpackage
`default_nettype wire

>>> hw/rtl/fresnel_reflectance_unpolarized_top.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance, unpolarized
// Streaming unit: ray direction, normal and two indices in, reflectance out.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle; the pipeline depth is set by the
// bit-per-stage cos^2 T divider (29 stages), the square root (29 stages)
// and the amplitude ratio dividers (19 stages). A stall on the output
// freezes the whole pipeline in place, so s_axis_tready is low only while
// a finished result waits and m_axis_tready is low.
`default_nettype none
`include "fresnel_reflectance_unpolarized_top_defines.svh"
module fresnel_reflectance_unpolarized_top
    import frp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_out, index_in
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // reflectance
    output logic [15:0]       m_axis_tdata,
    // total_internal
    output logic              m_axis_tuser
);

    logic        en;
    logic        fv, sv;
    logic [28:0] t2, t;
    side_t       fside, sside;

    logic               pv_reg   [0:TAIL_LAT-1];
    logic               full_reg [0:TAIL_LAT-1];
    logic               tir_reg  [0:TAIL_LAT-1];
    logic signed [46:0] a_reg, b_reg, a2_reg, b2_reg;
    logic signed [46:0] ns_reg, ds_reg, np_reg, dp_reg;

    logic [38:0] rs2, rp2;
    logic        zs, zp;
    logic [39:0] sum;
    logic [40:0] rnd;
    logic [15:0] refl_next;

    logic        out_vld_reg;
    logic [15:0] refl_reg;
    logic        otir_reg;

    assign en            = ~out_vld_reg | m_axis_tready;
    assign s_axis_tready = en;

    frp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .dx        (s_axis_tdata[15:0]),
        .dy        (s_axis_tdata[31:16]),
        .dz        (s_axis_tdata[47:32]),
        .nx        (s_axis_tdata[63:48]),
        .ny        (s_axis_tdata[79:64]),
        .nz        (s_axis_tdata[95:80]),
        .n1        (s_axis_tdata[111:96]),
        .n2        (s_axis_tdata[127:112]),
        .out_valid (fv),
        .t2        (t2),
        .side      (fside)
    );

    frp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv),
        .t2        (t2),
        .side_in   (fside),
        .out_valid (sv),
        .t         (t),
        .side_out  (sside)
    );

    frp_ratio u_rs (
        .clk  (clk),
        .en   (en),
        .num  (ns_reg),
        .den  (ds_reg),
        .sq   (rs2),
        .zero (zs)
    );

    frp_ratio u_rp (
        .clk  (clk),
        .en   (en),
        .num  (np_reg),
        .den  (dp_reg),
        .sq   (rp2),
        .zero (zp)
    );

    always_comb
    begin
        sum = 40'(rs2) + 40'(rp2);
        rnd = 41'(sum) + (41'd1 << 21);
        if (full_reg[TAIL_LAT-1] || zs || zp)
        begin
            refl_next = FULL_Q15;
        end
        else if (rnd[40:22] > 19'(FULL_Q15))
        begin
            refl_next = FULL_Q15;
        end
        else
        begin
            refl_next = rnd[37:22];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAIL_LAT; k++)
            begin
                pv_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg[0] <= sv;
            for (int k = 1; k < TAIL_LAT; k++)
            begin
                pv_reg[k] <= pv_reg[k-1];
            end
            out_vld_reg <= pv_reg[TAIL_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= $signed({31'd0, sside.n1}) * 47'(sside.c);
            b_reg  <= $signed({31'd0, sside.n2}) * $signed({18'd0, t});
            a2_reg <= $signed({31'd0, sside.n1}) * $signed({18'd0, t});
            b2_reg <= $signed({31'd0, sside.n2}) * 47'(sside.c);
            full_reg[0] <= sside.tir | sside.nz;
            tir_reg[0]  <= sside.tir;

            ns_reg <= a_reg - b_reg;
            ds_reg <= a_reg + b_reg;
            np_reg <= a2_reg - b2_reg;
            dp_reg <= a2_reg + b2_reg;
            for (int k = 1; k < TAIL_LAT; k++)
            begin
                full_reg[k] <= full_reg[k-1];
                tir_reg[k]  <= tir_reg[k-1];
            end

            refl_reg <= refl_next;
            otir_reg <= tir_reg[TAIL_LAT-1];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = refl_reg;
    assign m_axis_tuser  = otir_reg;

    `FRP_ASSERT(a_tir_full,
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == FULL_Q15,
        "tir without full reflectance")
    `FRP_ASSERT(a_refl_range, m_axis_tvalid |-> m_axis_tdata <= FULL_Q15,
        "reflectance above one")
    `FRP_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready,
        "input blocked with empty output")
    `FRP_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
        pv_reg[TAIL_LAT-1] == $past(pv_reg[TAIL_LAT-1]), "pipeline moved during stall")

endmodule
`default_nettype wire

>>> hw/rtl/frp_front.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance front end
// Dot product, sin^2 I, total internal reflection test and cos^2 T division.
// ----------------------------------------------------------------------------
`default_nettype none
module frp_front
    import frp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire vec_t        dx,
    input  wire vec_t        dy,
    input  wire vec_t        dz,
    input  wire vec_t        nx,
    input  wire vec_t        ny,
    input  wire vec_t        nz,
    input  wire idx_t        n1,
    input  wire idx_t        n2,
    output logic             out_valid,
    output logic [28:0]      t2,
    output side_t            side
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [31:0] p0_reg, p1_reg, p2_reg;
    idx_t  n1_1_reg, n2_1_reg;
    logic [31:0] n1sq_1_reg, n2sq_1_reg;

    cos_t  c2_reg, c3_reg, c4_reg, c5_reg;
    idx_t  n1_2_reg, n2_2_reg, n1_3_reg, n2_3_reg, n1_4_reg, n2_4_reg, n1_5_reg, n2_5_reg;
    logic [31:0] n1sq_2_reg, n2sq_2_reg, n1sq_3_reg, n2sq_3_reg, n1sq_4_reg;
    logic [31:0] n2sq_4_reg, n2sq_5_reg;
    logic nz2_reg, nz3_reg, nz4_reg, nz5_reg;
    logic [56:0] csq_reg;
    logic [28:0] sin2_reg;
    logic [60:0] lhs_reg;

    logic        dv_reg   [0:DIV_STEPS];
    logic [59:0] rem_reg  [0:DIV_STEPS];
    logic [31:0] d_reg    [0:DIV_STEPS];
    logic [28:0] q_reg    [0:DIV_STEPS];
    side_t       sd_reg   [0:DIV_STEPS];

    logic signed [33:0] negd_next;
    cos_t               c2_next;
    cos_t               cabs;
    logic [57:0]        csq_next;
    logic [56:0]        sdiff;
    logic [59:0]        rhs;
    logic               tir_next;
    side_t              sd_next;
    logic [59:0]        trial  [0:DIV_STEPS-1];
    logic               ge     [0:DIV_STEPS-1];

    always_comb
    begin
        negd_next = -(34'(p0_reg) + 34'(p1_reg) + 34'(p2_reg));
        if (negd_next > ONE_Q28)
        begin
            c2_next = 30'(ONE_Q28);
        end
        else if (negd_next < -ONE_Q28)
        begin
            c2_next = 30'(-ONE_Q28);
        end
        else
        begin
            c2_next = negd_next[29:0];
        end
        cabs     = c2_reg[29] ? -c2_reg : c2_reg;
        csq_next = 58'(cabs[28:0]) * 58'(cabs[28:0]);
        sdiff    = {1'b1, 56'd0} - csq_reg;
        rhs      = {n2sq_5_reg, 28'd0};
        tir_next = lhs_reg > {1'b0, rhs};
        sd_next.tir = tir_next & ~nz5_reg;
        sd_next.nz  = nz5_reg;
        sd_next.n1  = n1_5_reg;
        sd_next.n2  = n2_5_reg;
        sd_next.c   = c5_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial[k] = {28'd0, d_reg[k]} << (DIV_STEPS - 1 - k);
            ge[k]    = rem_reg[k] >= trial[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg     <= dx * nx;
            p1_reg     <= dy * ny;
            p2_reg     <= dz * nz;
            n1_1_reg   <= n1;
            n2_1_reg   <= n2;
            n1sq_1_reg <= 32'(n1) * 32'(n1);
            n2sq_1_reg <= 32'(n2) * 32'(n2);

            c2_reg     <= c2_next;
            n1_2_reg   <= n1_1_reg;
            n2_2_reg   <= n2_1_reg;
            n1sq_2_reg <= n1sq_1_reg;
            n2sq_2_reg <= n2sq_1_reg;
            nz2_reg    <= (n2_1_reg == 16'd0);

            csq_reg    <= csq_next[56:0];
            c3_reg     <= c2_reg;
            n1_3_reg   <= n1_2_reg;
            n2_3_reg   <= n2_2_reg;
            n1sq_3_reg <= n1sq_2_reg;
            n2sq_3_reg <= n2sq_2_reg;
            nz3_reg    <= nz2_reg;

            sin2_reg   <= sdiff[56:28];
            c4_reg     <= c3_reg;
            n1_4_reg   <= n1_3_reg;
            n2_4_reg   <= n2_3_reg;
            n1sq_4_reg <= n1sq_3_reg;
            n2sq_4_reg <= n2sq_3_reg;
            nz4_reg    <= nz3_reg;

            lhs_reg    <= 61'(n1sq_4_reg) * 61'(sin2_reg);
            c5_reg     <= c4_reg;
            n1_5_reg   <= n1_4_reg;
            n2_5_reg   <= n2_4_reg;
            n2sq_5_reg <= n2sq_4_reg;
            nz5_reg    <= nz4_reg;

            rem_reg[0] <= (tir_next || nz5_reg) ? 60'd0 : rhs - lhs_reg[59:0];
            d_reg[0]   <= n2sq_5_reg;
            q_reg[0]   <= 29'd0;
            sd_reg[0]  <= sd_next;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k+1] <= ge[k] ? rem_reg[k] - trial[k] : rem_reg[k];
                d_reg[k+1]   <= d_reg[k];
                q_reg[k+1]   <= {q_reg[k][27:0], ge[k]};
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    assign out_valid = dv_reg[DIV_STEPS];
    assign t2        = q_reg[DIV_STEPS];
    assign side      = sd_reg[DIV_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/frp_sqrt.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance square root
// Pipelined digit-by-digit integer square root of cos^2 T, one root bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module frp_sqrt
    import frp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [28:0] t2,
    input  wire side_t       side_in,
    output logic             out_valid,
    output logic [28:0]      t,
    output side_t            side_out
);

    logic        v_reg  [0:SQRT_STEPS];
    logic [57:0] x_reg  [0:SQRT_STEPS];
    logic [57:0] r_reg  [0:SQRT_STEPS];
    side_t       sd_reg [0:SQRT_STEPS];

    logic [57:0] bitv  [0:SQRT_STEPS-1];
    logic [57:0] trial [0:SQRT_STEPS-1];
    logic        ge    [0:SQRT_STEPS-1];

    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bitv[k]  = 58'd1 << (2 * (SQRT_STEPS - 1 - k));
            trial[k] = r_reg[k] + bitv[k];
            ge[k]    = x_reg[k] >= trial[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQRT_STEPS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= {1'b0, t2, 28'd0};
            r_reg[0]  <= 58'd0;
            sd_reg[0] <= side_in;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                x_reg[k+1]  <= ge[k] ? x_reg[k] - trial[k] : x_reg[k];
                r_reg[k+1]  <= ge[k] ? (r_reg[k] >> 1) + bitv[k] : r_reg[k] >> 1;
                sd_reg[k+1] <= sd_reg[k];
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS];
    assign t         = r_reg[SQRT_STEPS][28:0];
    assign side_out  = sd_reg[SQRT_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/frp_ratio.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance amplitude ratio
// Squared ratio |num/den|^2 in Q.36 through a pipelined restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module frp_ratio
    import frp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [46:0] num,
    input  wire logic signed [46:0] den,
    output logic [38:0]             sq,
    output logic                    zero
);

    logic [45:0] mn_reg, md_reg;
    logic        big_reg  [0:RAT_STEPS];
    logic        zero_reg [0:RAT_STEPS];
    logic [63:0] rem_reg  [0:RAT_STEPS];
    logic [45:0] d_reg    [0:RAT_STEPS];
    logic [18:0] q_reg    [0:RAT_STEPS];
    logic [38:0] sq_reg;
    logic        zo_reg;

    logic signed [46:0] num_abs, den_abs;
    logic [37:0]        qsq;
    logic [63:0]        trial [0:RAT_STEPS-1];
    logic               ge    [0:RAT_STEPS-1];

    always_comb
    begin
        num_abs = num[46] ? -num : num;
        den_abs = den[46] ? -den : den;
        qsq     = 38'(q_reg[RAT_STEPS]) * 38'(q_reg[RAT_STEPS]);
        for (int k = 0; k < RAT_STEPS; k++)
        begin
            trial[k] = {18'd0, d_reg[k]} << (RAT_STEPS - 1 - k);
            ge[k]    = rem_reg[k] >= trial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mn_reg      <= num_abs[45:0];
            md_reg      <= den_abs[45:0];
            big_reg[0]  <= {1'b0, mn_reg} >= {md_reg, 1'b0};
            zero_reg[0] <= (md_reg == 46'd0);
            rem_reg[0]  <= {mn_reg, 18'd0};
            d_reg[0]    <= md_reg;
            q_reg[0]    <= 19'd0;
            for (int k = 0; k < RAT_STEPS; k++)
            begin
                big_reg[k+1]  <= big_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                rem_reg[k+1]  <= ge[k] ? rem_reg[k] - trial[k] : rem_reg[k];
                d_reg[k+1]    <= d_reg[k];
                q_reg[k+1]    <= {q_reg[k][17:0], ge[k]};
            end
            sq_reg <= big_reg[RAT_STEPS] ? (39'd1 << 38) : {1'b0, qsq};
            zo_reg <= zero_reg[RAT_STEPS];
        end
    end

    assign sq   = sq_reg;
    assign zero = zo_reg;

endmodule
`default_nettype wire
